// ----- rtl/co2ta_pkg.sv -----
// Shared widths, register indexes, reset values and arithmetic constants for
// the CO2 threshold aggressiveness block. No dependencies.
package co2ta_pkg;

  localparam int TEMP_W  = 15;
  localparam int PPM_W   = 14;
  localparam int AGGR_W  = 14;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int IDX_W   = 3;

  // register indexes (byte address = 4 * index)
  localparam logic [IDX_W-1:0] REG_SETPOINT    = 3'd0;
  localparam logic [IDX_W-1:0] REG_CONS_HIGH   = 3'd1;
  localparam logic [IDX_W-1:0] REG_CONS_MEDIUM = 3'd2;
  localparam logic [IDX_W-1:0] REG_CONS_LOW    = 3'd3;
  localparam logic [IDX_W-1:0] REG_AGGR_HIGH   = 3'd4;
  localparam logic [IDX_W-1:0] REG_AGGR_MEDIUM = 3'd5;
  localparam logic [IDX_W-1:0] REG_AGGR_LOW    = 3'd6;

  localparam logic signed [TEMP_W-1:0] RST_SETPOINT    = 15'sd2000;
  localparam logic [PPM_W-1:0]         RST_CONS_HIGH   = 14'd2500;
  localparam logic [PPM_W-1:0]         RST_CONS_MEDIUM = 14'd2000;
  localparam logic [PPM_W-1:0]         RST_CONS_LOW    = 14'd1500;
  localparam logic [PPM_W-1:0]         RST_AGGR_HIGH   = 14'd1000;
  localparam logic [PPM_W-1:0]         RST_AGGR_MEDIUM = 14'd700;
  localparam logic [PPM_W-1:0]         RST_AGGR_LOW    = 14'd400;

  // datapath widths
  localparam int DIFF_W = 16;  // temperature differences
  localparam int S_W    = 18;  // 2b +/- c
  localparam int T_W    = 31;  // 3000 * (2b +/- c)
  localparam int P_W    = 32;  // b * c
  localparam int N_W    = 36;  // unclamped numerator
  localparam int NC_W   = 25;  // clamped numerator, 0..18000000
  localparam int X_W    = 31;  // 64*n + 70312
  localparam int K_W    = 32;  // reciprocal constant
  localparam int PR_W   = X_W + K_W;
  localparam int Q_SHIFT = 49;

  localparam logic signed [T_W-1:0] SCALE_3K  = 31'sd3000;
  localparam logic signed [N_W-1:0] UNIT_N    = 36'sd9000000;
  localparam logic signed [N_W-1:0] MAX_N     = 36'sd18000000;
  localparam logic signed [N_W-1:0] ZERO_N    = 36'sd0;
  localparam logic [X_W-1:0]        X_BIAS    = 31'd70312;
  // ceil(2^49 / 140625): exact floor division for every x below 2^31
  localparam logic [K_W-1:0]        RECIP_K   = 32'd4003199669;

  typedef struct packed {
    logic signed [TEMP_W-1:0] setpoint_temp;
    logic [PPM_W-1:0]         conservative_high_ppm;
    logic [PPM_W-1:0]         conservative_medium_ppm;
    logic [PPM_W-1:0]         conservative_low_ppm;
    logic [PPM_W-1:0]         aggressive_high_ppm;
    logic [PPM_W-1:0]         aggressive_medium_ppm;
    logic [PPM_W-1:0]         aggressive_low_ppm;
  } cfg_t;

endpackage

// ----- rtl/co2ta_if.sv -----
// Valid/ready channel interfaces for temperature samples and threshold results.
// Depends on co2ta_pkg.
interface co2ta_sample_if import co2ta_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] room_cdeg;
  logic signed [TEMP_W-1:0] inlet_cdeg;

  modport source (output valid, room_cdeg, inlet_cdeg, input ready);
  modport sink   (input valid, room_cdeg, inlet_cdeg, output ready);
endinterface

interface co2ta_result_if import co2ta_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AGGR_W-1:0] aggressiveness;
  logic [PPM_W-1:0]  high_ppm;
  logic [PPM_W-1:0]  medium_ppm;
  logic [PPM_W-1:0]  low_ppm;

  modport source (output valid, aggressiveness, high_ppm, medium_ppm, low_ppm, input ready);
  modport sink   (input valid, aggressiveness, high_ppm, medium_ppm, low_ppm, output ready);
endinterface

// ----- rtl/co2ta_cfg.sv -----
// APB register file: setpoint and the two threshold sets.
// Depends on co2ta_pkg.
module co2ta_cfg import co2ta_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [IDX_W-1:0] idx;
  logic             wr;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint_temp           <= RST_SETPOINT;
      cfg.conservative_high_ppm   <= RST_CONS_HIGH;
      cfg.conservative_medium_ppm <= RST_CONS_MEDIUM;
      cfg.conservative_low_ppm    <= RST_CONS_LOW;
      cfg.aggressive_high_ppm     <= RST_AGGR_HIGH;
      cfg.aggressive_medium_ppm   <= RST_AGGR_MEDIUM;
      cfg.aggressive_low_ppm      <= RST_AGGR_LOW;
    end else if (wr) begin
      unique case (idx)
        REG_SETPOINT:    cfg.setpoint_temp           <= pwdata[TEMP_W-1:0];
        REG_CONS_HIGH:   cfg.conservative_high_ppm   <= pwdata[PPM_W-1:0];
        REG_CONS_MEDIUM: cfg.conservative_medium_ppm <= pwdata[PPM_W-1:0];
        REG_CONS_LOW:    cfg.conservative_low_ppm    <= pwdata[PPM_W-1:0];
        REG_AGGR_HIGH:   cfg.aggressive_high_ppm     <= pwdata[PPM_W-1:0];
        REG_AGGR_MEDIUM: cfg.aggressive_medium_ppm   <= pwdata[PPM_W-1:0];
        REG_AGGR_LOW:    cfg.aggressive_low_ppm      <= pwdata[PPM_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SETPOINT:    prdata = PDATA_W'(cfg.setpoint_temp);  // sign-extended
      REG_CONS_HIGH:   prdata = PDATA_W'(cfg.conservative_high_ppm);
      REG_CONS_MEDIUM: prdata = PDATA_W'(cfg.conservative_medium_ppm);
      REG_CONS_LOW:    prdata = PDATA_W'(cfg.conservative_low_ppm);
      REG_AGGR_HIGH:   prdata = PDATA_W'(cfg.aggressive_high_ppm);
      REG_AGGR_MEDIUM: prdata = PDATA_W'(cfg.aggressive_medium_ppm);
      REG_AGGR_LOW:    prdata = PDATA_W'(cfg.aggressive_low_ppm);
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- rtl/co2ta_aggr.sv -----
// Four-stage pipeline from a temperature sample to the 4096-per-unit
// aggressiveness. Depends on co2ta_pkg and co2ta_sample_if.
module co2ta_aggr import co2ta_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [TEMP_W-1:0] setpoint_temp,
  co2ta_sample_if.sink             sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [AGGR_W-1:0]        aggressiveness
);

  // stage 1: differences against setpoint
  logic                     v1, rdy1;
  logic signed [DIFF_W-1:0] b1, c1;
  logic                     skew1;
  logic signed [DIFF_W-1:0] b_c, c_c;

  // stage 2: products
  logic                     v2, rdy2;
  logic signed [T_W-1:0]    t2;
  logic signed [P_W-1:0]    bc2;
  logic                     skew2;
  logic signed [S_W-1:0]    s_c, t_c;

  // stage 3: clamped numerator, biased for rounding
  logic                     v3, rdy3;
  logic [X_W-1:0]           x3;
  logic signed [N_W-1:0]    n_c, bc4_c;
  logic [NC_W-1:0]          nc_c;

  // stage 4: division by 140625 through the reciprocal
  logic                     v4, rdy4;
  logic [PR_W-1:0]          prod_c;

  assign rdy4 = !v4 || out_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign sample.ready = rdy1;
  assign out_valid = v4;

  assign b_c = DIFF_W'(sample.inlet_cdeg) - DIFF_W'(setpoint_temp);
  assign c_c = DIFF_W'(sample.room_cdeg) - DIFF_W'(setpoint_temp);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1    <= sample.valid;
      b1    <= b_c;
      c1    <= c_c;
      skew1 <= b_c[DIFF_W-1] ^ c_c[DIFF_W-1];  // inlet and room on opposite sides
    end
  end

  // no skew: -3000*(2b-c)*dir; skew: +3000*(2b+c)*dir; dir negative when c < 0
  always_comb begin
    s_c = skew1 ? ((S_W'(b1) <<< 1) + S_W'(c1)) : ((S_W'(b1) <<< 1) - S_W'(c1));
    t_c = (skew1 == c1[DIFF_W-1]) ? -s_c : s_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2    <= v1;
      t2    <= T_W'(t_c) * SCALE_3K;
      bc2   <= P_W'(b1) * P_W'(c1);
      skew2 <= skew1;
    end
  end

  always_comb begin
    bc4_c = N_W'(bc2) <<< 2;
    n_c   = UNIT_N + N_W'(t2) - (skew2 ? bc4_c : ZERO_N);
    if (n_c < ZERO_N) begin
      nc_c = '0;
    end else if (n_c > MAX_N) begin
      nc_c = MAX_N[NC_W-1:0];
    end else begin
      nc_c = n_c[NC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
      x3 <= {nc_c, 6'b0} + X_BIAS;  // 64*n + 70312
    end
  end

  assign prod_c = PR_W'(x3) * PR_W'(RECIP_K);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4             <= v3;
      aggressiveness <= prod_c[Q_SHIFT +: AGGR_W];
    end
  end

endmodule

// ----- rtl/co2ta_lerp.sv -----
// Output stage: interpolates the three CO2 thresholds and holds the result
// item. Depends on co2ta_pkg and co2ta_result_if.
module co2ta_lerp import co2ta_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [AGGR_W-1:0] aggressiveness,
  co2ta_result_if.source    result
);

  localparam int L_W = 30;

  logic rdy;

  // floor((cons*8192 + (aggr - cons)*q) / 8192); numerator never negative
  function automatic logic [PPM_W-1:0] lerp(input logic [PPM_W-1:0] cons,
                                            input logic [PPM_W-1:0] aggr,
                                            input logic [AGGR_W-1:0] q);
    logic signed [L_W-1:0] cs, diff, num;
    cs   = L_W'($signed({1'b0, cons}));
    diff = L_W'($signed({1'b0, aggr})) - cs;
    num  = (cs <<< 13) + diff * L_W'($signed({1'b0, q}));
    return num[13 +: PPM_W];
  endfunction

  assign rdy          = !result.valid || result.ready;
  assign in_ready     = rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (rdy) begin
      result.valid          <= in_valid;
      result.aggressiveness <= aggressiveness;
      result.high_ppm       <= lerp(cfg.conservative_high_ppm,
                                    cfg.aggressive_high_ppm, aggressiveness);
      result.medium_ppm     <= lerp(cfg.conservative_medium_ppm,
                                    cfg.aggressive_medium_ppm, aggressiveness);
      result.low_ppm        <= lerp(cfg.conservative_low_ppm,
                                    cfg.aggressive_low_ppm, aggressiveness);
    end
  end

endmodule

// ----- rtl/co2_threshold_aggressiveness.sv -----
// CO2 threshold aggressiveness, top level.
// Depends on co2ta_pkg, co2ta_if, co2ta_cfg, co2ta_aggr and co2ta_lerp.
//
// Usage:
//  - sample channel (valid/ready) carries room_cdeg and inlet_cdeg in
//    hundredths of a degree, two's complement.
//  - result channel (valid/ready) carries aggressiveness (4096 = 1.0, 0..8192)
//    and the interpolated high, medium and low CO2 thresholds in ppm.
//  - APB port holds the setpoint and the conservative/aggressive threshold
//    sets at byte addresses 0x00..0x18; pready is tied high. Write only while
//    no item is in flight.
//  - Five register stages: stages 1..4, then the output register. One item
//    per cycle sustained while the result channel is ready; the depth is
//    set by the two multiplier stages and the reciprocal divide.
//  - A stall on the result channel holds each occupied stage; empty stages
//    keep filling, so the sample channel stays ready until the pipe is full.
//  - Synchronous reset empties the pipe and loads the default setpoint
//    (20.00 degrees) and thresholds.
module co2_threshold_aggressiveness import co2ta_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  co2ta_sample_if.sink       sample,
  co2ta_result_if.source     result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t              cfg;
  logic              aggr_valid;
  logic              aggr_ready;
  logic [AGGR_W-1:0] aggr_value;

  // register file
  co2ta_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stages 1..4: differences, products, clamp, reciprocal divide
  co2ta_aggr u_aggr (
    .clk            (clk),
    .rst            (rst),
    .setpoint_temp  (cfg.setpoint_temp),
    .sample         (sample),
    .out_valid      (aggr_valid),
    .out_ready      (aggr_ready),
    .aggressiveness (aggr_value)
  );

  // stage 5: threshold interpolation into the output register
  co2ta_lerp u_lerp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (aggr_valid),
    .in_ready       (aggr_ready),
    .aggressiveness (aggr_value),
    .result         (result)
  );

endmodule

// ----- tb/tb_co2_threshold_aggressiveness.sv -----
// Self-checking testbench for co2_threshold_aggressiveness: temperature samples in,
// interpolated CO2 thresholds out, with each result checked against a local model.
// Depends on co2ta_pkg, co2ta_if and the block's RTL.
`timescale 1ns / 100ps

module tb_co2_threshold_aggressiveness;
  import co2ta_pkg::*;

  localparam int PIPE_DEPTH  = 5;     // register stages through the block
  localparam int STALL_LIMIT = 4000;  // cycles with no item moving before giving up
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;

  typedef struct {
    logic signed [TEMP_W-1:0] room;
    logic signed [TEMP_W-1:0] inlet;
  } sample_t;

  typedef struct {
    logic [AGGR_W-1:0] aggressiveness;
    logic [PPM_W-1:0]  high_ppm;
    logic [PPM_W-1:0]  medium_ppm;
    logic [PPM_W-1:0]  low_ppm;
  } thresholds_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  co2ta_sample_if sample ();
  co2ta_result_if result ();

  co2_threshold_aggressiveness dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample.sink),
    .result  (result.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the register file, updated as each write lands
  cfg_t        shadow_cfg;
  sample_t     samples_pending[$];
  thresholds_t thresholds_due[$];
  int          send_idle_pct;
  int          stall_pct;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Interpolate one threshold between its conservative and aggressive ends.
  // Truncates toward zero; the numerator is floored at zero for safety.
  function automatic logic [PPM_W-1:0] blend_ppm(input logic [PPM_W-1:0] cons,
                                                 input logic [PPM_W-1:0] aggr,
                                                 input longint q);
    longint c;
    longint g;
    longint num;
    c = cons;
    g = aggr;
    num = c * 8192 + (g - c) * q;
    if (num < 0) num = 0;
    return PPM_W'(num / 8192);
  endfunction

  // Aggressiveness from the temperature differences, then the three thresholds.
  function automatic thresholds_t predict_thresholds(input logic signed [TEMP_W-1:0] room_t,
                                                     input logic signed [TEMP_W-1:0] inlet_t,
                                                     input cfg_t c);
    longint      room;
    longint      inlet;
    longint      sp;
    longint      a;
    longint      b;
    longint      d;
    longint      dir;
    longint      n;
    longint      q;
    bit          skew;
    thresholds_t r;
    room  = room_t;
    inlet = inlet_t;
    sp    = c.setpoint_temp;
    a = inlet - room;
    b = inlet - sp;
    d = room - sp;
    dir = (d >= 0) ? 1 : -1;   // room exactly at setpoint counts as above
    // inlet drives the room across the setpoint
    skew = (room >= sp && inlet < sp) || (room < sp && inlet >= sp);
    if (skew) n = 64'sd9000000 + 3000 * (a + b + 2 * d) * dir - 4 * b * d;
    else      n = 64'sd9000000 - 3000 * (a + b) * dir;
    if (n < 0) n = 0;
    if (n > 18000000) n = 18000000;
    // N * 4096 / 9e6, nearest, ties up
    q = (n * 128 + 140625) / 281250;
    r.aggressiveness = AGGR_W'(q);
    r.high_ppm   = blend_ppm(c.conservative_high_ppm, c.aggressive_high_ppm, q);
    r.medium_ppm = blend_ppm(c.conservative_medium_ppm, c.aggressive_medium_ppm, q);
    r.low_ppm    = blend_ppm(c.conservative_low_ppm, c.aggressive_low_ppm, q);
    return r;
  endfunction

  // Mostly plausible readings, some close to the setpoint, some raw 15-bit patterns.
  function automatic logic signed [TEMP_W-1:0] pick_temp(input logic signed [TEMP_W-1:0] sp);
    int v;
    int sel;
    sel = $urandom_range(9);
    case (sel) inside
      5, 6: v = int'(sp) + int'($urandom_range(200)) - 100;
      7: v = $urandom;
      8: begin
        case ($urandom_range(3))
          0: v = -16384;
          1: v = 16383;
          2: v = -4000;
          default: v = 8500;
        endcase
      end
      9: v = sp;
      default: v = int'($urandom_range(12500)) - 4000;
    endcase
    return v[TEMP_W-1:0];
  endfunction

  function automatic logic [PPM_W-1:0] pick_ppm();
    if ($urandom_range(7) == 0) return PPM_W'($urandom_range(16383));
    return PPM_W'($urandom_range(10000));
  endfunction

  // APB write: setup cycle, then access cycle; register lands on the access edge.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [PDATA_W-1:0] word);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SETPOINT:    shadow_cfg.setpoint_temp           = word[TEMP_W-1:0];
      REG_CONS_HIGH:   shadow_cfg.conservative_high_ppm   = word[PPM_W-1:0];
      REG_CONS_MEDIUM: shadow_cfg.conservative_medium_ppm = word[PPM_W-1:0];
      REG_CONS_LOW:    shadow_cfg.conservative_low_ppm    = word[PPM_W-1:0];
      REG_AGGR_HIGH:   shadow_cfg.aggressive_high_ppm     = word[PPM_W-1:0];
      REG_AGGR_MEDIUM: shadow_cfg.aggressive_medium_ppm   = word[PPM_W-1:0];
      REG_AGGR_LOW:    shadow_cfg.aggressive_low_ppm      = word[PPM_W-1:0];
      default: ;  // unmapped index, block ignores it
    endcase
  endtask

  // Write the whole register set; upper data bits carry junk the block must drop.
  task automatic load_cfg(input cfg_t c);
    logic [PDATA_W-1:0] word;
    word = $urandom; word[TEMP_W-1:0] = c.setpoint_temp;          write_reg(REG_SETPOINT, word);
    word = $urandom; word[PPM_W-1:0]  = c.conservative_high_ppm;   write_reg(REG_CONS_HIGH, word);
    word = $urandom; word[PPM_W-1:0]  = c.conservative_medium_ppm; write_reg(REG_CONS_MEDIUM, word);
    word = $urandom; word[PPM_W-1:0]  = c.conservative_low_ppm;    write_reg(REG_CONS_LOW, word);
    word = $urandom; word[PPM_W-1:0]  = c.aggressive_high_ppm;     write_reg(REG_AGGR_HIGH, word);
    word = $urandom; word[PPM_W-1:0]  = c.aggressive_medium_ppm;   write_reg(REG_AGGR_MEDIUM, word);
    word = $urandom; word[PPM_W-1:0]  = c.aggressive_low_ppm;      write_reg(REG_AGGR_LOW, word);
  endtask

  // Sender holds off until every item is through and the pipe has emptied.
  task automatic drain();
    while (samples_pending.size() != 0 || sample.valid || thresholds_due.size() != 0)
      @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  task automatic queue_sample(input int room, input int inlet);
    sample_t s;
    s.room  = room[TEMP_W-1:0];
    s.inlet = inlet[TEMP_W-1:0];
    samples_pending.push_back(s);
  endtask

  // Driver: on acceptance the expected thresholds are recorded with the live
  // register shadow, then the next item (or a gap) is put on the channel.
  always @(posedge clk) begin
    if (rst) begin
      sample.valid <= 1'b0;
    end else begin
      if (sample.valid && sample.ready)
        thresholds_due.push_back(predict_thresholds(sample.room_cdeg, sample.inlet_cdeg,
                                                    shadow_cfg));
      if (!sample.valid || sample.ready) begin
        if (samples_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample.valid      <= 1'b1;
          sample.room_cdeg  <= samples_pending[0].room;
          sample.inlet_cdeg <= samples_pending[0].inlet;
          void'(samples_pending.pop_front());
        end else begin
          sample.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: each accepted result against the oldest expectation, field by field.
  always @(posedge clk) begin
    thresholds_t want;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (thresholds_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: aggr %0d high %0d medium %0d low %0d",
                     result.aggressiveness, result.high_ppm, result.medium_ppm,
                     result.low_ppm);
          mismatches++;
        end else begin
          want = thresholds_due.pop_front();
          if (result.aggressiveness !== want.aggressiveness ||
              result.high_ppm !== want.high_ppm ||
              result.medium_ppm !== want.medium_ppm ||
              result.low_ppm !== want.low_ppm) begin
            if (mismatches < 10)
              $display("mismatch: aggr %0d/%0d high %0d/%0d medium %0d/%0d low %0d/%0d",
                       want.aggressiveness, result.aggressiveness,
                       want.high_ppm, result.high_ppm,
                       want.medium_ppm, result.medium_ppm,
                       want.low_ppm, result.low_ppm);
            mismatches++;
          end
        end
      end
      result.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: nothing moving on either channel for too long ends the run.
  always @(posedge clk) begin
    if (rst || (sample.valid && sample.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    cfg_t c;
    int   p;
    int   k;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    shadow_cfg.setpoint_temp           = RST_SETPOINT;
    shadow_cfg.conservative_high_ppm   = RST_CONS_HIGH;
    shadow_cfg.conservative_medium_ppm = RST_CONS_MEDIUM;
    shadow_cfg.conservative_low_ppm    = RST_CONS_LOW;
    shadow_cfg.aggressive_high_ppm     = RST_AGGR_HIGH;
    shadow_cfg.aggressive_medium_ppm   = RST_AGGR_MEDIUM;
    shadow_cfg.aggressive_low_ppm      = RST_AGGR_LOW;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed items on reset defaults (setpoint 20.00): setpoint crossings
    // both ways, room exactly at setpoint, clamps at 0 and 2, field extremes.
    queue_sample(2000, 2000);
    queue_sample(1999, 2000);
    queue_sample(2000, 1999);
    queue_sample(1999, 1999);
    queue_sample(2001, 2001);
    queue_sample(8500, 8500);
    queue_sample(-4000, -4000);
    queue_sample(-4000, 8500);
    queue_sample(8500, -4000);
    queue_sample(8500, 2500);
    queue_sample(-4000, 1000);
    queue_sample(-16384, -16384);
    queue_sample(16383, 16383);
    queue_sample(-16384, 16383);
    queue_sample(16383, -16384);
    queue_sample(0, 0);
    queue_sample(-1, 0);
    queue_sample(2500, 1500);
    queue_sample(1500, 2500);
    queue_sample(2000, 8500);
    queue_sample(2000, -4000);
    queue_sample(3000, 3000);
    queue_sample(1000, 1000);
    drain();

    // An unmapped index must leave every register untouched.
    write_reg(IDX_W'(7), 32'hFFFF_FFFF);

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          c.setpoint_temp = -15'sd4000;
          c.conservative_high_ppm = 14'd10000; c.aggressive_high_ppm = 14'd0;
          c.conservative_medium_ppm = 14'd0;   c.aggressive_medium_ppm = 14'd10000;
          c.conservative_low_ppm = 14'd10000;  c.aggressive_low_ppm = 14'd10000;
        end
        1: begin
          c.setpoint_temp = 15'sd8500;
          c.conservative_high_ppm = 14'd0;     c.aggressive_high_ppm = 14'd10000;
          c.conservative_medium_ppm = 14'd10000; c.aggressive_medium_ppm = 14'd0;
          c.conservative_low_ppm = 14'd0;      c.aggressive_low_ppm = 14'd0;
        end
        2: begin
          // raw pattern extremes, beyond the documented ranges
          c.setpoint_temp = -15'sd16384;
          c.conservative_high_ppm = 14'd16383; c.aggressive_high_ppm = 14'd0;
          c.conservative_medium_ppm = 14'd0;   c.aggressive_medium_ppm = 14'd16383;
          c.conservative_low_ppm = 14'd16383;  c.aggressive_low_ppm = 14'd16383;
        end
        3: begin
          c.setpoint_temp = 15'sd16383;
          c.conservative_high_ppm = 14'd16383; c.aggressive_high_ppm = 14'd1;
          c.conservative_medium_ppm = 14'd1;   c.aggressive_medium_ppm = 14'd16383;
          c.conservative_low_ppm = 14'd8191;   c.aggressive_low_ppm = 14'd8192;
        end
        default: begin
          c.setpoint_temp = (p == PHASES - 1) ? RST_SETPOINT
                                              : pick_temp(15'sd2000);
          c.conservative_high_ppm   = pick_ppm();
          c.conservative_medium_ppm = pick_ppm();
          c.conservative_low_ppm    = pick_ppm();
          c.aggressive_high_ppm     = pick_ppm();
          c.aggressive_medium_ppm   = pick_ppm();
          c.aggressive_low_ppm      = pick_ppm();
        end
      endcase
      load_cfg(c);
      @(negedge clk);

      // idling pattern rotates: none, sender gaps, receiver stalls, both light
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase

      // half the phase, full pause, then the rest
      for (k = 0; k < PHASE_ITEMS; k++) begin
        queue_sample(pick_temp(shadow_cfg.setpoint_temp), pick_temp(shadow_cfg.setpoint_temp));
        if (k == PHASE_ITEMS / 2) drain();
      end
      drain();
    end

    if (mismatches == 0 && thresholds_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/co2ta_pkg.sv
rtl/co2ta_if.sv
rtl/co2ta_cfg.sv
rtl/co2ta_aggr.sv
rtl/co2ta_lerp.sv
rtl/co2_threshold_aggressiveness.sv
tb/tb_co2_threshold_aggressiveness.sv
